[rtl/core/cee_pkg.sv]
package cee_pkg;

  localparam int TLB_ENTRIES = 32;
  localparam int TLB_AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int RANGE_W = 64;

  // opcodes
  localparam logic [1:0] OP_REFILL  = 2'd0;
  localparam logic [1:0] OP_GENERAL = 2'd1;
  localparam logic [1:0] OP_WR_EVEN = 2'd2;
  localparam logic [1:0] OP_WR_ODD  = 2'd3;

  // access kinds
  localparam logic [1:0] ACC_STORE = 2'd1;
  localparam logic [1:0] ACC_FETCH = 2'd2;

  localparam logic [31:0] VEC_GENERAL = 32'h8000_0180;
  localparam logic [31:0] VEC_REFILL  = 32'h8000_0000;
  localparam logic [31:0] CTX_KEEP    = 32'hFF80_000F;
  localparam logic [31:0] CTX_BADVPN  = 32'h007F_FFF0;
  localparam logic [31:0] VPN_MASK    = 32'hFFFF_E000;
  localparam logic [31:0] CAUSE_TLBL  = 32'h0000_0008;
  localparam logic [31:0] CAUSE_TLBS  = 32'h0000_000C;
  localparam logic [31:0] BD_BIT      = 32'h8000_0000;

  typedef struct packed {
    logic              en;
    logic              odd;
    logic [TLB_AW-1:0] idx;
    logic [31:0]       lo;
    logic [31:0]       hi;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [TLB_AW-1:0] idx;
  } tbl_rd_t;

endpackage

[rtl/core/cee_ram.sv]
module cee_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/cee_range_table.sv]
module cee_range_table (
  input  logic            clk,
  input  logic            rst,
  input  cee_pkg::tbl_wr_t wr,
  input  cee_pkg::tbl_rd_t rd,
  input  logic [31:0]     cmp_addr,
  output logic            hit
);
  import cee_pkg::*;

  logic [TLB_ENTRIES-1:0] vld_even;
  logic [TLB_ENTRIES-1:0] vld_odd;
  logic                   rd_q;
  logic                   vq_even;
  logic                   vq_odd;
  logic [RANGE_W-1:0]     rdata_even;
  logic [RANGE_W-1:0]     rdata_odd;
  logic                   hit_even;
  logic                   hit_odd;

  cee_ram #(.WIDTH(RANGE_W), .DEPTH(TLB_ENTRIES)) u_even (
    .clk   (clk),
    .we    (wr.en && !wr.odd),
    .waddr (wr.idx),
    .wdata ({wr.lo, wr.hi}),
    .re    (rd.en),
    .raddr (rd.idx),
    .rdata (rdata_even)
  );

  cee_ram #(.WIDTH(RANGE_W), .DEPTH(TLB_ENTRIES)) u_odd (
    .clk   (clk),
    .we    (wr.en && wr.odd),
    .waddr (wr.idx),
    .wdata ({wr.lo, wr.hi}),
    .re    (rd.en),
    .raddr (rd.idx),
    .rdata (rdata_odd)
  );

  // an entry never written reads as an empty range
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_even <= '0;
      vld_odd  <= '0;
      rd_q     <= 1'b0;
    end else begin
      if (wr.en && !wr.odd) begin
        vld_even[wr.idx] <= 1'b1;
      end
      if (wr.en && wr.odd) begin
        vld_odd[wr.idx] <= 1'b1;
      end
      rd_q <= rd.en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      vq_even <= vld_even[rd.idx];
      vq_odd  <= vld_odd[rd.idx];
    end
  end

  assign hit_even = vq_even && (cmp_addr >= rdata_even[63:32]) &&
                    (cmp_addr <= rdata_even[31:0]);
  assign hit_odd  = vq_odd && (cmp_addr >= rdata_odd[63:32]) &&
                    (cmp_addr <= rdata_odd[31:0]);
  assign hit      = rd_q && (hit_even || hit_odd);

endmodule

[rtl/core/cop0_exception_entry.sv]
// Table writes, general exceptions, KSEG0 refills and refills with EXL set:
//   the request is registered, then moves to the outputs from ST_DONE.
// Other refills scan every table entry, one read of each range memory per
//   cycle, then pass ST_DRAIN and ST_DONE. No request is taken until the last
//   result is loaded out. Synchronous reset clears control state and marks
//   every range entry empty; the block takes requests once reset is released.
module cop0_exception_entry (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [1:0]  access_kind,
  input  logic [31:0] address,
  input  logic [31:0] pc,
  input  logic        in_delay_slot,
  input  logic        exl_in,
  input  logic [31:0] cause_in,
  input  logic [31:0] context_in,
  input  logic [31:0] epc_in,
  input  logic [4:0]  tlb_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic [31:0] epc,
  output logic [31:0] cause,
  output logic        exl_out,
  output logic [31:0] bad_vaddr,
  output logic [31:0] context_out,
  output logic [31:0] entry_hi
);
  import cee_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [TLB_AW-1:0] cnt;
  logic              scan_hit;
  logic              tbl_hit;
  logic              accept;
  logic              load_out;
  logic              is_write;
  logic              need_scan;
  logic              fetch;
  logic              idx_ok;
  logic [1:0]        dec;
  logic [31:0]       base;
  tbl_wr_t           tbl_wr;
  tbl_rd_t           tbl_rd;

  // result computed from the request at the input
  logic [31:0] r_next_pc, r_epc, r_cause, r_bad, r_ctx, r_ehi;
  logic        r_exl;
  logic [31:0] w_next_pc, w_epc, w_cause, w_bad, w_ctx, w_ehi, w_addr;
  logic        w_exl;

  assign accept   = in_valid && !in_stall;
  assign in_stall = rst || (state != ST_IDLE);
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);
  assign is_write = (opcode == OP_WR_EVEN) || (opcode == OP_WR_ODD);
  assign fetch    = (access_kind == ACC_FETCH);
  assign idx_ok   = (32'(tlb_index) < TLB_ENTRIES);
  assign need_scan = (opcode == OP_REFILL) && !exl_in && (address[31:30] != 2'b10);

  assign tbl_wr.en  = accept && is_write && idx_ok;
  assign tbl_wr.odd = (opcode == OP_WR_ODD);
  assign tbl_wr.idx = TLB_AW'(tlb_index);
  assign tbl_wr.lo  = address;
  assign tbl_wr.hi  = pc;

  assign tbl_rd.en  = (state == ST_SCAN);
  assign tbl_rd.idx = cnt;

  cee_range_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .rd       (tbl_rd),
    .cmp_addr (w_addr),
    .hit      (tbl_hit)
  );

  // refill EPC: one word back for a load or store, one more in a delay slot
  assign dec  = {1'b0, in_delay_slot} + {1'b0, !fetch};
  assign base = fetch ? address : pc;

  always_comb begin
    r_next_pc = 32'd0;
    r_epc     = epc_in;
    r_cause   = cause_in;
    r_exl     = exl_in;
    r_bad     = 32'd0;
    r_ctx     = context_in;
    r_ehi     = 32'd0;
    unique case (opcode)
      OP_REFILL: begin
        r_cause = (access_kind == ACC_STORE) ? CAUSE_TLBS : CAUSE_TLBL;
        if (in_delay_slot) begin
          r_cause = r_cause | BD_BIT;
        end
        r_bad = address;
        r_ctx = (context_in & CTX_KEEP) | ((address >> 9) & CTX_BADVPN);
        r_ehi = address & VPN_MASK;
        if (!exl_in) begin
          r_epc = base - {28'd0, dec, 2'b00};
        end
        r_next_pc = need_scan ? VEC_REFILL : VEC_GENERAL;
        r_exl     = 1'b1;
      end
      OP_GENERAL: begin
        r_cause = in_delay_slot ? (cause_in | BD_BIT) : (cause_in & ~BD_BIT);
        if (!exl_in) begin
          r_epc = pc - {29'd0, in_delay_slot, 2'b00};
        end
        r_next_pc = VEC_GENERAL;
        r_exl     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = need_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (cnt == TLB_AW'(TLB_ENTRIES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      scan_hit  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt      <= '0;
        scan_hit <= 1'b0;
      end else begin
        if (state == ST_SCAN) begin
          cnt <= cnt + 1'b1;
        end
        if (tbl_hit) begin
          scan_hit <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_next_pc <= r_next_pc;
      w_epc     <= r_epc;
      w_cause   <= r_cause;
      w_exl     <= r_exl;
      w_bad     <= r_bad;
      w_ctx     <= r_ctx;
      w_ehi     <= r_ehi;
      w_addr    <= address;
    end else if (state == ST_DRAIN && (scan_hit || tbl_hit)) begin
      w_next_pc <= VEC_GENERAL;
    end
    if (load_out) begin
      next_pc     <= w_next_pc;
      epc         <= w_epc;
      cause       <= w_cause;
      exl_out     <= w_exl;
      bad_vaddr   <= w_bad;
      context_out <= w_ctx;
      entry_hi    <= w_ehi;
    end
  end

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> (state == ST_IDLE))
    else $error("range table written while a request is in flight");

  a_drain_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> ($past(state) == ST_SCAN) &&
                            ($past(cnt) == TLB_AW'(TLB_ENTRIES - 1)))
    else $error("drain entered before the last entry was read");

  a_scan_hit_only_scan: assert property (@(posedge clk) disable iff (rst)
    tbl_hit |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("range hit outside a scan");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN || state == ST_DONE))
    else $error("accepted request did not start");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && (state == ST_IDLE))
    else $error("result load did not present output");

endmodule

[sim/cop0_exception_entry_test.sv]
module cop0_exception_entry_test;
  import cee_pkg::*;

  localparam logic [31:0] KSEG0_BASE = 32'h8000_0000;
  localparam logic [31:0] KSEG1_BASE = 32'hC000_0000;
  localparam int RANDOM_REQUESTS = 1350;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] pc;
    logic        ds;
    logic        exl;
    logic [31:0] cause_in;
    logic [31:0] ctx_in;
    logic [31:0] epc_in;
    logic [4:0]  idx;
  } req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] epc;
    logic [31:0] cause;
    logic        exl;
    logic [31:0] bad_vaddr;
    logic [31:0] ctx;
    logic [31:0] ehi;
  } res_t;

  // Tracks the translation ranges and the cop0 updates still owed by the block.
  class entry_checker;
    logic [31:0] even_lo[TLB_ENTRIES];
    logic [31:0] even_hi[TLB_ENTRIES];
    logic [31:0] odd_lo[TLB_ENTRIES];
    logic [31:0] odd_hi[TLB_ENTRIES];
    res_t cop0_updates[$];
    int errors;

    function new();
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        even_lo[i] = '1;
        even_hi[i] = '0;
        odd_lo[i] = '1;
        odd_hi[i] = '0;
      end
      errors = 0;
    endfunction

    function bit takes_general_vector(logic [31:0] a);
      bit hit;
      hit = (a >= KSEG0_BASE) && (a < KSEG1_BASE);
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if ((a >= even_lo[i] && a <= even_hi[i]) || (a >= odd_lo[i] && a <= odd_hi[i]))
          hit = 1'b1;
      end
      return hit;
    endfunction

    function res_t enter_exception(req_t r);
      res_t u;
      bit fetch;
      u.next_pc = '0;
      u.epc = r.epc_in;
      u.cause = r.cause_in;
      u.exl = r.exl;
      u.bad_vaddr = '0;
      u.ctx = r.ctx_in;
      u.ehi = '0;
      case (r.op)
        OP_WR_EVEN, OP_WR_ODD: begin
          if (r.idx < TLB_ENTRIES) begin
            if (r.op == OP_WR_EVEN) begin
              even_lo[r.idx] = r.addr;
              even_hi[r.idx] = r.pc;
            end else begin
              odd_lo[r.idx] = r.addr;
              odd_hi[r.idx] = r.pc;
            end
          end
        end
        OP_REFILL: begin
          fetch = (r.kind == ACC_FETCH);
          u.cause = (r.kind == ACC_STORE) ? CAUSE_TLBS : CAUSE_TLBL;
          if (r.ds) u.cause |= BD_BIT;
          u.bad_vaddr = r.addr;
          u.ctx = (r.ctx_in & CTX_KEEP) | ((r.addr >> 9) & CTX_BADVPN);
          u.ehi = r.addr & VPN_MASK;
          if (r.exl) begin
            // already at exception level: no scan, EPC kept
            u.next_pc = VEC_GENERAL;
          end else begin
            u.epc = fetch ? r.addr : r.pc;
            if (r.ds) u.epc -= 32'd4;
            if (!fetch) u.epc -= 32'd4;
            u.next_pc = takes_general_vector(r.addr) ? VEC_GENERAL : VEC_REFILL;
          end
          u.exl = 1'b1;
        end
        default: begin
          u.cause = r.ds ? (r.cause_in | BD_BIT) : (r.cause_in & ~BD_BIT);
          if (!r.exl) u.epc = r.ds ? r.pc - 32'd4 : r.pc;
          u.next_pc = VEC_GENERAL;
          u.exl = 1'b1;
        end
      endcase
      return u;
    endfunction

    function void note_request(req_t r);
      cop0_updates.push_back(enter_exception(r));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (cop0_updates.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: next_pc %h epc %h cause %h", got.next_pc, got.epc,
                   got.cause);
        return;
      end
      want = cop0_updates.pop_front();
      if (got.next_pc !== want.next_pc || got.epc !== want.epc || got.cause !== want.cause ||
          got.exl !== want.exl || got.bad_vaddr !== want.bad_vaddr ||
          got.ctx !== want.ctx || got.ehi !== want.ehi) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch (expected/actual): next_pc %h/%h epc %h/%h cause %h/%h exl %b/%b",
                   want.next_pc, got.next_pc, want.epc, got.epc, want.cause, got.cause,
                   want.exl, got.exl);
          $display("  bad_vaddr %h/%h context %h/%h entry_hi %h/%h", want.bad_vaddr,
                   got.bad_vaddr, want.ctx, got.ctx, want.ehi, got.ehi);
        end
      end
    endfunction

    function int pending();
      return cop0_updates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [1:0]  access_kind;
  logic [31:0] address;
  logic [31:0] pc;
  logic        in_delay_slot;
  logic        exl_in;
  logic [31:0] cause_in;
  logic [31:0] context_in;
  logic [31:0] epc_in;
  logic [4:0]  tlb_index;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] next_pc;
  logic [31:0] epc;
  logic [31:0] cause;
  logic        exl_out;
  logic [31:0] bad_vaddr;
  logic [31:0] context_out;
  logic [31:0] entry_hi;

  entry_checker board;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_len = 0;
  logic [31:0] marks[16];

  cop0_exception_entry dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .access_kind(access_kind),
    .address(address),
    .pc(pc),
    .in_delay_slot(in_delay_slot),
    .exl_in(exl_in),
    .cause_in(cause_in),
    .context_in(context_in),
    .epc_in(epc_in),
    .tlb_index(tlb_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .next_pc(next_pc),
    .epc(epc),
    .cause(cause),
    .exl_out(exl_out),
    .bad_vaddr(bad_vaddr),
    .context_out(context_out),
    .entry_hi(entry_hi)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t make_req(logic [1:0] op, logic [1:0] kind, logic [31:0] a,
                                    logic [31:0] p, logic ds, logic exl, logic [4:0] idx);
    req_t r;
    r.op = op;
    r.kind = kind;
    r.addr = a;
    r.pc = p;
    r.ds = ds;
    r.exl = exl;
    r.cause_in = rand_word();
    r.ctx_in = rand_word();
    r.epc_in = rand_word();
    r.idx = idx;
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode <= r.op;
    access_kind <= r.kind;
    address <= r.addr;
    pc <= r.pc;
    in_delay_slot <= r.ds;
    exl_in <= r.exl;
    cause_in <= r.cause_in;
    context_in <= r.ctx_in;
    epc_in <= r.epc_in;
    tlb_index <= r.idx;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin : result_side
    int gap;
    res_t got;
    out_stall = 1'b0;
    forever begin
      gap = recv_idle ? $urandom_range(0, 4) : 0;
      if (hold_len > 0) begin
        gap = hold_len;
        hold_len = 0;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.next_pc = next_pc;
      got.epc = epc;
      got.cause = cause;
      got.exl = exl_out;
      got.bad_vaddr = bad_vaddr;
      got.ctx = context_out;
      got.ehi = entry_hi;
      board.check_result(got);
    end
  end

  initial begin
    #8_000_000;
    $display("cop0_exception_entry regression: fail");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    int sel;
    logic [31:0] lo, hi;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_REFILL;
    access_kind = '0;
    address = '0;
    pc = '0;
    in_delay_slot = 1'b0;
    exl_in = 1'b0;
    cause_in = '0;
    context_in = '0;
    epc_in = '0;
    tlb_index = '0;
    for (int i = 0; i < 16; i++) marks[i] = KSEG0_BASE - 32'd1 + 32'(i);
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // segment edges and vector choice with an empty table
    send_request(make_req(OP_REFILL, 2'd0, 32'h0000_1000, 32'h0040_0010, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, ACC_STORE, 32'h0000_2000, 32'h0040_0020, 1'b1, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, ACC_FETCH, 32'h0040_0000, 32'h0040_0004, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, ACC_FETCH, 32'h0000_0000, 32'h0000_0004, 1'b1, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, 2'd3, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 5'd31));
    send_request(make_req(OP_REFILL, 2'd0, KSEG0_BASE, 32'h8000_1000, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, 2'd0, 32'hBFFF_FFFF, 32'h8000_1000, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, 2'd0, KSEG1_BASE, 32'h8000_1000, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, 2'd0, 32'h7FFF_FFFF, 32'h8000_1000, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, ACC_STORE, 32'h1234_5678, 32'h0040_0100, 1'b1, 1'b1, 5'd0));
    // range bounds are inclusive
    send_request(make_req(OP_WR_EVEN, 2'd0, 32'h1000_0000, 32'h1000_1FFF, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, 2'd0, 32'h1000_0000, 32'h0040_0000, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, 2'd1, 32'h1000_1FFF, 32'h0040_0000, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, 2'd0, 32'h1000_2000, 32'h0040_0000, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_REFILL, 2'd2, 32'h0FFF_FFFF, 32'h0040_0000, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_WR_ODD, 2'd3, 32'hFFFF_F000, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd31));
    send_request(make_req(OP_REFILL, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0));
    // reversed range matches nothing
    send_request(make_req(OP_WR_EVEN, 2'd0, 32'h2000_0000, 32'h1FFF_FFFF, 1'b0, 1'b0, 5'd5));
    send_request(make_req(OP_REFILL, 2'd0, 32'h2000_0000, 32'h0040_0000, 1'b0, 1'b0, 5'd0));
    send_request(make_req(OP_WR_ODD, 2'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 5'd3));
    send_request(make_req(OP_REFILL, 2'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 5'd0));
    r = make_req(OP_GENERAL, 2'd0, 32'h0000_0000, 32'h0040_0200, 1'b0, 1'b0, 5'd0);
    r.cause_in = '1;
    send_request(r);
    send_request(make_req(OP_GENERAL, 2'd3, '1, 32'h0000_0000, 1'b1, 1'b0, 5'd0));
    send_request(make_req(OP_GENERAL, 2'd0, '1, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd0));
    send_request(make_req(OP_WR_EVEN, 2'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 5'd0));

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 0) begin
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
      end
      if (n == 400) begin
        // block the result side while requests keep coming, fill the pipe
        hold_len = 300;
        send_idle = 1'b0;
      end
      if (n == 800) drain();
      sel = $urandom_range(0, 99);
      r = make_req(OP_REFILL, 2'($urandom_range(0, 3)), rand_word(), rand_word(),
                   1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                   5'($urandom_range(0, 31)));
      if (sel < 20) begin
        r.op = (sel < 10) ? OP_WR_EVEN : OP_WR_ODD;
        lo = rand_word();
        case ($urandom_range(0, 3))
          0: hi = lo + $urandom_range(0, 4095);
          1: hi = lo + $urandom_range(0, 1 << 20);
          2: hi = lo;
          default: hi = lo - 32'd1 - $urandom_range(0, 255);
        endcase
        r.addr = lo;
        r.pc = hi;
        marks[$urandom_range(0, 15)] = lo;
        marks[$urandom_range(0, 15)] = hi;
      end else if (sel < 40) begin
        r.op = OP_GENERAL;
      end else begin
        // aim refills at range edges and KSEG0 so both vectors show up
        case ($urandom_range(0, 3))
          0, 1: r.addr = marks[$urandom_range(0, 15)] + $urandom_range(0, 2) - 1;
          2: r.addr = {2'b10, 30'($urandom)};
          default: ;
        endcase
      end
      send_request(r);
    end

    drain();
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("cop0_exception_entry regression: pass");
    end else begin
      $display("cop0_exception_entry regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/cee_pkg.sv
rtl/core/cee_ram.sv
rtl/core/cee_range_table.sv
rtl/core/cop0_exception_entry.sv
sim/cop0_exception_entry_test.sv
